/* hw/rtl/motor_reply_frame_receiver_top_assert.svh */
// Assertion macros used by the top level of the motor reply frame receiver RTL.
`ifndef MOTOR_REPLY_FRAME_RECEIVER_TOP_ASSERT_SVH
`define MOTOR_REPLY_FRAME_RECEIVER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MRFR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("motor reply frame receiver: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MRFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("motor reply frame receiver: assertion failed");

`endif

/* hw/rtl/mrfr_pkg.sv */
// Types, constants and the CRC function of the motor reply frame receiver.
`default_nettype none
package mrfr_pkg;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [7:0]  FN_READ        = 8'h43;
	localparam logic [7:0]  FN_WRITE       = 8'h44;
	localparam logic [31:0] ADDR_SPEED     = 32'h0051_0050;
	localparam logic [31:0] ADDR_ENCODER   = 32'h1551_1550;
	localparam logic [31:0] ADDR_SET_SPEED = 32'h0031_0021;
	localparam logic [31:0] ADDR_ENABLE    = 32'h1833_1823;

	localparam logic [14:0] STEP_LIMIT_RESET = 15'd2000;

	typedef enum logic [2:0] {
		ST_SHORT       = 3'd0,
		ST_CRC_BAD     = 3'd1,
		ST_SPEED       = 3'd2,
		ST_ENCODER     = 3'd3,
		ST_WRITE_ACK   = 3'd4,
		ST_OTHER       = 3'd5,
		ST_UNDECODABLE = 3'd6
	} status_t;

	// Summary of a frame at its final byte, handed from the framer to the decoder.
	typedef struct packed {
		logic        crc_ok;
		logic        too_short;
		logic        undecodable;
		logic [7:0]  fn;
		logic [31:0] addr;
		logic [15:0] lv;
		logic [15:0] rv;
	} frame_info_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] lv;
		logic [15:0] rv;
		logic [15:0] ld;
		logic [15:0] rd;
		logic        dv;
	} result_t;

	// One byte of the reflected Modbus CRC-16.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/mrfr_if.sv */
// Handshake channel interfaces of the motor reply frame receiver.
`default_nettype none
interface mrfr_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       last_byte;
	modport source (output valid, output rx_byte, output last_byte, input ready);
	modport sink (input valid, input rx_byte, input last_byte, output ready);
endinterface

interface mrfr_res_if;
	logic              valid;
	logic              ready;
	logic [2:0]        frame_status;
	logic signed [15:0] left_value;
	logic signed [15:0] right_value;
	logic signed [15:0] left_delta;
	logic signed [15:0] right_delta;
	logic              delta_valid;
	modport source (output valid, output frame_status, output left_value, output right_value,
		output left_delta, output right_delta, output delta_valid, input ready);
	modport sink (input valid, input frame_status, input left_value, input right_value,
		input left_delta, input right_delta, input delta_valid, output ready);
endinterface

interface mrfr_cfg_if;
	logic        valid;
	logic        ready;
	logic [14:0] step_limit;
	modport source (output valid, output step_limit, input ready);
	modport sink (input valid, input step_limit, output ready);
endinterface
`default_nettype wire

/* hw/rtl/mrfr_frame.sv */
// Frame tracker: CRC accumulation, byte count, byte delay line and header capture.
`default_nettype none
module mrfr_frame
	import mrfr_pkg::*;
#(
	parameter int MAX_FRAME_LEN = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        adv,
	input  wire logic [7:0]  byte_s1,
	input  wire logic        last_s1,
	output frame_info_t      info
);

	localparam int CW = $clog2(MAX_FRAME_LEN + 1);

	logic [15:0]   crc_q;
	logic [CW-1:0] count_q;
	logic [7:0]    dly0_q;
	logic [7:0]    dly1_q;
	logic [7:0]    hdr_q [0:8];
	logic [7:0]    hdr_eff [0:8];
	logic [15:0]   crc_upd;
	logic          crc_take;

	// The byte two places back is known not to belong to the CRC field.
	assign crc_take = (count_q >= CW'(2));
	assign crc_upd  = crc_take ? crc16_byte(crc_q, dly1_q) : crc_q;

	for (genvar i = 0; i < 9; i++) begin : g_hdr
		assign hdr_eff[i] = (count_q == CW'(i + 1)) ? byte_s1 : hdr_q[i];

		always_ff @(posedge clk) begin
			if (adv && (count_q == CW'(i + 1))) begin
				hdr_q[i] <= byte_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= CRC_INIT;
			count_q <= '0;
		end else if (adv) begin
			if (last_s1) begin
				crc_q   <= CRC_INIT;
				count_q <= '0;
			end else begin
				crc_q <= crc_upd;
				if (count_q < CW'(MAX_FRAME_LEN)) begin
					count_q <= count_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dly0_q <= byte_s1;
			dly1_q <= dly0_q;
		end
	end

	always_comb begin
		info.crc_ok      = (crc_upd == {byte_s1, dly0_q});
		info.too_short   = (count_q < CW'(5));
		info.undecodable = (count_q < CW'(9));
		info.fn          = hdr_eff[0];
		info.addr        = {hdr_eff[4], hdr_eff[3], hdr_eff[2], hdr_eff[1]};
		info.lv          = {hdr_eff[5], hdr_eff[6]};
		info.rv          = {hdr_eff[7], hdr_eff[8]};
	end

endmodule
`default_nettype wire

/* hw/rtl/mrfr_decode.sv */
// Frame classifier, encoder delta check and result register.
`default_nettype none
module mrfr_decode
	import mrfr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        frame_end,
	input  wire frame_info_t info,
	input  wire logic [14:0] step_limit,
	input  wire logic        res_ready,
	output logic             res_valid,
	output result_t          res
);

	logic [15:0]        prev_left_q;
	logic [15:0]        prev_right_q;
	logic               valid_q;
	result_t            res_q;
	result_t            res_d;
	logic signed [16:0] ld_x;
	logic signed [16:0] rd_x;
	logic signed [16:0] lim_p;
	logic signed [16:0] lim_n;
	logic [15:0]        ld_raw;
	logic [15:0]        rd_raw;

	assign ld_raw = info.lv - prev_left_q;
	assign rd_raw = prev_right_q - info.rv;
	assign ld_x   = signed'({ld_raw[15], ld_raw});
	assign rd_x   = signed'({rd_raw[15], rd_raw});
	assign lim_p  = signed'({2'b00, step_limit});
	assign lim_n  = -lim_p;

	always_comb begin
		res_d = '0;
		priority if (info.too_short) begin
			res_d.status = ST_SHORT;
		end else if (!info.crc_ok) begin
			res_d.status = ST_CRC_BAD;
		end else if (info.undecodable) begin
			res_d.status = ST_UNDECODABLE;
		end else begin
			res_d.lv = info.lv;
			res_d.rv = info.rv;
			priority if (info.fn == FN_READ && info.addr == ADDR_SPEED) begin
				res_d.status = ST_SPEED;
			end else if (info.fn == FN_READ && info.addr == ADDR_ENCODER) begin
				res_d.status = ST_ENCODER;
				res_d.ld     = ld_raw;
				res_d.rd     = rd_raw;
				res_d.dv     = (ld_x <= lim_p) && (ld_x >= lim_n) &&
					(rd_x <= lim_p) && (rd_x >= lim_n);
			end else if (info.fn == FN_WRITE &&
				(info.addr == ADDR_SET_SPEED || info.addr == ADDR_ENABLE)) begin
				res_d.status = ST_WRITE_ACK;
			end else begin
				res_d.status = ST_OTHER;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= 1'b0;
			prev_left_q  <= '0;
			prev_right_q <= '0;
		end else begin
			if (frame_end) begin
				valid_q <= 1'b1;
			end else if (res_ready) begin
				valid_q <= 1'b0;
			end
			if (frame_end && res_d.status == ST_ENCODER) begin
				prev_left_q  <= info.lv;
				prev_right_q <= info.rv;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frame_end) begin
			res_q <= res_d;
		end
	end

	assign res_valid = valid_q;
	assign res       = res_q;

endmodule
`default_nettype wire

/* hw/rtl/motor_reply_frame_receiver_top.sv */
// Top level of the motor reply frame receiver.
// Path: a byte accepted from rx sits in the input stage; if it ends a frame and the result register
// is free or being emptied, its result is registered there and offered on the result channel.
// Throughput: one byte per cycle; only a held result stalls the input, via the result register.
// Reset: arst_n clears the frame state, previous counts, valid flags and sets step_limit to 2000.
`default_nettype none
module motor_reply_frame_receiver_top
	import mrfr_pkg::*;
#(
	parameter int MAX_FRAME_LEN = 256
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	mrfr_rx_if.sink     rx,
	mrfr_res_if.source  res,
	mrfr_cfg_if.sink    cfg
);

`include "motor_reply_frame_receiver_top_assert.svh"

	// Input stage: one accepted byte transaction waits here while the frame logic
	// folds it into the running CRC and header capture.
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        adv_s1;
	logic [14:0] step_limit_q;
	logic        res_valid;
	frame_info_t info;
	result_t     res_data;

	// A byte that does not end a frame always moves on, since it produces no result.
	// A final byte moves on only when the result register is free or being emptied.
	assign adv_s1   = valid_s1 && (!last_s1 || !res_valid || res.ready);
	assign rx.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
			last_s1 <= rx.last_byte;
		end
	end

	// The step limit register accepts a write transaction in every cycle.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_limit_q <= STEP_LIMIT_RESET;
		end else if (cfg.valid) begin
			step_limit_q <= cfg.step_limit;
		end
	end

	mrfr_frame #(
		.MAX_FRAME_LEN(MAX_FRAME_LEN)
	) u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv_s1),
		.byte_s1 (byte_s1),
		.last_s1 (last_s1),
		.info    (info)
	);

	mrfr_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame_end  (adv_s1 && last_s1),
		.info       (info),
		.step_limit (step_limit_q),
		.res_ready  (res.ready),
		.res_valid  (res_valid),
		.res        (res_data)
	);

	// Result channel driven straight from the result register.
	assign res.valid        = res_valid;
	assign res.frame_status = res_data.status;
	assign res.left_value   = signed'(res_data.lv);
	assign res.right_value  = signed'(res_data.rv);
	assign res.left_delta   = signed'(res_data.ld);
	assign res.right_delta  = signed'(res_data.rd);
	assign res.delta_valid  = res_data.dv;

	// A new result only appears after a final byte left the input stage.
	`MRFR_ASSERT_IMPL(a_res_from_last, clk, arst_n, $rose(res_valid), $past(adv_s1 && last_s1))
	// An empty input stage never refuses a byte.
	`MRFR_ASSERT_IMPL(a_ready_when_empty, clk, arst_n, !valid_s1, rx.ready)
	// Only encoder replies can flag a valid step.
	`MRFR_ASSERT_IMPL(a_dv_encoder, clk, arst_n, res_valid && res_data.dv,
		res_data.status == ST_ENCODER)

endmodule
`default_nettype wire
